/* hw/rtl/ax25_hdlc_frame_encoder_macros.svh */
// assertion macros for the ax25 frame encoder
// expects clk and rst in the scope of use; no other dependencies
`ifndef AX25_HDLC_FRAME_ENCODER_MACROS_SVH
`define AX25_HDLC_FRAME_ENCODER_MACROS_SVH

// same-cycle implication
`define AX25_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ax25 encoder check failed");

// next-cycle implication
`define AX25_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ax25 encoder check failed");

`endif

/* hw/rtl/ax25_pkg.sv */
// shared types and constants of the ax25 frame encoder
// no dependencies
package ax25_pkg;

  localparam int CALL_W = 48;

  localparam logic [7:0]  FLAG_BYTE      = 8'h7E;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [7:0]  SSID_BASE      = 8'h60;
  localparam logic [7:0]  DEST_SSID_BITS = 8'h1C;
  localparam logic [7:0]  U_CTRL         = 8'h03;
  localparam logic [7:0]  SRC_SSID_BITS  = 8'h01;

  localparam logic [1:0] KIND_INFO  = 2'd0;
  localparam logic [1:0] KIND_UNNUM = 2'd2;

  localparam logic CFG_DEST = 1'b0;
  localparam logic CFG_SRC  = 1'b1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic [1:0] frame_kind;
    logic [2:0] send_seq;
    logic [2:0] recv_seq;
    logic       data_type;
    logic       command_flag;
  } in_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_frame;
  } out_t;

  typedef enum logic [1:0] {
    OP_OPEN,
    OP_SEND,
    OP_PAD,
    OP_CLOSE
  } line_op_t;

  typedef struct packed {
    logic       valid;
    line_op_t   op;
    logic [7:0] data;
    logic       crc_on;
  } line_req_t;

  typedef struct packed {
    logic take;
    logic busy;
  } line_stat_t;

  typedef struct packed {
    logic en;
    logic din;
  } crc_feed_t;

endpackage

/* hw/rtl/ax25_hdlc_frame_encoder.sv */
// ax25 frame encoder top level: frame sequencer, callsign registers, crc and line units
// depends on ax25_pkg, ax25_crc, ax25_line and ax25_hdlc_frame_encoder_macros.svh
//
// usage
// - in channel (in_valid/in_ready/in_data) takes one payload byte per transfer with its
//   frame controls; a byte with first_of_frame opens a frame, one with last_of_frame
//   closes it, a byte outside a frame without first_of_frame is dropped
// - out channel (out_valid/out_ready/out_data) gives line bytes, first line bit at the
//   msb; end_of_frame marks the closing flag
// - cfg_we/cfg_index/cfg_data write the destination (index 0) and source (index 1)
//   callsigns; write them only while no frame is in progress
// - each byte goes to the line as 8 bits plus one per stuffed zero (8 to 10), shifted one
//   bit per cycle while out_ready does not hold the serializer; the serializer sets the rate
// - a payload byte is taken while the one before is still shifting, so inside a frame the
//   in channel can accept the next byte before the serializer is through with the last
// - the first byte of a frame is preceded by the opening flag and 16 header bytes; the
//   last is followed by two crc bytes, the pad byte and the closing flag
// - after the first transfer, state S_OPEN loads the opening flag into the free output register
// - when out_ready is low the serializer holds at the next full byte and the
//   in channel stops after one buffered byte; nothing is lost
// - rst (synchronous) empties the frame state and clears both callsigns
`include "ax25_hdlc_frame_encoder_macros.svh"

module ax25_hdlc_frame_encoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ax25_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ax25_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [ax25_pkg::CALL_W-1:0]    cfg_data
);
  import ax25_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPEN,
    S_HDR,
    S_PAY,
    S_FCS_HI,
    S_FCS_LO,
    S_PAD,
    S_CLOSE
  } state_t;

  localparam logic [3:0] HDR_DEST_SSID = 4'd6;
  localparam logic [3:0] HDR_SRC_SSID  = 4'd13;
  localparam logic [3:0] HDR_CTRL      = 4'd14;
  localparam logic [3:0] HDR_PID       = 4'd15;

  state_t              state;
  logic                in_frame;
  in_t                 item;
  logic [3:0]          hdr_idx;
  logic [CALL_W-1:0]   call_sr;
  logic [CALL_W-1:0]   dest_callsign;
  logic [CALL_W-1:0]   src_callsign;
  logic [7:0]          ctrl_byte;
  logic [7:0]          hdr_byte;
  logic [15:0]         crc;
  logic                crc_init;
  logic                in_acc;
  line_req_t           req;
  line_stat_t          lstat;
  crc_feed_t           feed;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_callsign <= '0;
      src_callsign  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEST: dest_callsign <= cfg_data;
        CFG_SRC:  src_callsign  <= cfg_data;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign crc_init = lstat.take && (state == S_OPEN);

  always_comb begin
    if (item.frame_kind == KIND_INFO) begin
      ctrl_byte = {item.recv_seq, 1'b0, item.send_seq, 1'b0};
    end else if (item.frame_kind == KIND_UNNUM) begin
      ctrl_byte = U_CTRL;
    end else begin
      ctrl_byte = 8'h00;
    end
  end

  always_comb begin
    case (hdr_idx)
      HDR_DEST_SSID: hdr_byte = SSID_BASE | DEST_SSID_BITS | {6'd0, item.data_type, 1'b0}
                                | {item.command_flag, 7'd0};
      HDR_SRC_SSID:  hdr_byte = SSID_BASE | SRC_SSID_BITS | {!item.command_flag, 7'd0};
      HDR_CTRL:      hdr_byte = ctrl_byte;
      HDR_PID:       hdr_byte = 8'h00;
      default:       hdr_byte = {call_sr[CALL_W-2 -: 7], 1'b0};
    endcase
  end

  always_comb begin
    req = '0;
    unique case (state)
      S_IDLE: req = '0;
      S_OPEN: begin
        req.valid = 1'b1;
        req.op    = OP_OPEN;
      end
      S_HDR: begin
        req.valid  = 1'b1;
        req.op     = OP_SEND;
        req.data   = hdr_byte;
        req.crc_on = 1'b1;
      end
      S_PAY: begin
        req.valid  = 1'b1;
        req.op     = OP_SEND;
        req.data   = item.payload_byte;
        req.crc_on = 1'b1;
      end
      S_FCS_HI: begin
        req.valid = 1'b1;
        req.op    = OP_SEND;
        req.data  = ~crc[15:8];
      end
      S_FCS_LO: begin
        req.valid = 1'b1;
        req.op    = OP_SEND;
        req.data  = ~crc[7:0];
      end
      S_PAD: begin
        req.valid = 1'b1;
        req.op    = OP_PAD;
      end
      S_CLOSE: begin
        req.valid = 1'b1;
        req.op    = OP_CLOSE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_frame <= 1'b0;
      hdr_idx  <= 4'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            item <= in_data;
            if (in_data.first_of_frame) begin
              state    <= S_OPEN;
              in_frame <= 1'b1;
              call_sr  <= dest_callsign;
            end else if (in_frame) begin
              state <= S_PAY;
            end
          end
        end
        S_OPEN: begin
          if (lstat.take) begin
            state   <= S_HDR;
            hdr_idx <= 4'd0;
          end
        end
        S_HDR: begin
          if (lstat.take) begin
            hdr_idx <= hdr_idx + 4'd1;
            if (hdr_idx == HDR_DEST_SSID) begin
              call_sr <= src_callsign;
            end else begin
              call_sr <= {call_sr[CALL_W-9:0], 8'h00};
            end
            if (hdr_idx == HDR_PID) begin
              state <= S_PAY;
            end
          end
        end
        S_PAY: begin
          if (lstat.take) begin
            state <= item.last_of_frame ? S_FCS_HI : S_IDLE;
          end
        end
        S_FCS_HI: begin
          if (lstat.take) begin
            state <= S_FCS_LO;
          end
        end
        S_FCS_LO: begin
          if (lstat.take) begin
            state <= S_PAD;
          end
        end
        S_PAD: begin
          if (lstat.take) begin
            state <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          if (lstat.take) begin
            state    <= S_IDLE;
            in_frame <= 1'b0;
          end
        end
      endcase
    end
  end

  ax25_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .init (crc_init),
    .feed (feed),
    .crc  (crc)
  );

  ax25_line u_line (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .stat      (lstat),
    .feed      (feed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `AX25_CHECK(eof_is_flag, out_valid && out_data.end_of_frame, out_data.line_byte == FLAG_BYTE)
  `AX25_CHECK_NEXT(stray_byte_dropped, in_acc && !in_data.first_of_frame && !in_frame, state == S_IDLE)
  `AX25_CHECK_NEXT(open_resets_crc, crc_init, crc == CRC_INIT)

endmodule

/* hw/rtl/ax25_crc.sv */
// bit-serial crc-16-ccitt register, one data bit per cycle while feed.en is high
// depends on ax25_pkg
module ax25_crc (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  init,
  input  ax25_pkg::crc_feed_t   feed,
  output logic [15:0]           crc
);
  import ax25_pkg::*;

  logic fb;

  assign fb = crc[15] ^ feed.din;

  always_ff @(posedge clk) begin
    if (rst || init) begin
      crc <= CRC_INIT;
    end else if (feed.en) begin
      crc <= {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
  end

endmodule

/* hw/rtl/ax25_line.sv */
// line serializer: lsb-first bits, zero stuffing, byte packing and output register
// depends on ax25_pkg
module ax25_line (
  input  logic                   clk,
  input  logic                   rst,
  input  ax25_pkg::line_req_t    req,
  output ax25_pkg::line_stat_t   stat,
  output ax25_pkg::crc_feed_t    feed,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ax25_pkg::out_t         out_data
);
  import ax25_pkg::*;

  logic       busy;
  logic       stuff_pend;
  logic       crc_on;
  logic [3:0] cnt;
  logic [7:0] cur;
  logic [7:0] bits;
  logic [7:0] bits_next;
  logic [2:0] fill;
  logic [2:0] ones;
  logic       out_free;
  logic       line_b;
  logic       full_now;
  logic       advance;
  logic       take;

  assign out_free = !out_valid || out_ready;
  assign line_b   = stuff_pend ? 1'b0 : cur[cnt[2:0]];
  assign full_now = (fill == 3'd7);
  assign advance  = busy && (!full_now || out_free);
  assign take     = req.valid && !busy && ((req.op == OP_SEND) || out_free);

  always_comb begin
    bits_next = bits;
    bits_next[3'd7 - fill] = line_b;
  end

  assign feed.en   = advance && crc_on && !stuff_pend;
  assign feed.din  = cur[3'd7 - cnt[2:0]];
  assign stat.take = take;
  assign stat.busy = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      stuff_pend <= 1'b0;
      crc_on     <= 1'b0;
      cnt        <= 4'd0;
      ones       <= 3'd0;
      fill       <= 3'd0;
      bits       <= 8'h00;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (full_now) begin
          out_valid <= 1'b1;
          out_data  <= '{line_byte: bits_next, end_of_frame: 1'b0};
          bits      <= 8'h00;
          fill      <= 3'd0;
        end else begin
          bits <= bits_next;
          fill <= fill + 3'd1;
        end
        if (stuff_pend) begin
          stuff_pend <= 1'b0;
          if (cnt == 4'd8) begin
            busy <= 1'b0;
          end
        end else begin
          cnt <= cnt + 4'd1;
          if (line_b && (ones == 3'd4)) begin
            stuff_pend <= 1'b1;
            ones       <= 3'd0;
          end else begin
            ones <= line_b ? ones + 3'd1 : 3'd0;
            if (cnt == 4'd7) begin
              busy <= 1'b0;
            end
          end
        end
      end else if (take) begin
        unique case (req.op)
          OP_SEND: begin
            busy   <= 1'b1;
            cur    <= req.data;
            crc_on <= req.crc_on;
            cnt    <= 4'd0;
          end
          OP_OPEN: begin
            out_valid  <= 1'b1;
            out_data   <= '{line_byte: FLAG_BYTE, end_of_frame: 1'b0};
            bits       <= 8'h00;
            fill       <= 3'd0;
            ones       <= 3'd0;
            stuff_pend <= 1'b0;
          end
          OP_PAD: begin
            out_valid <= 1'b1;
            out_data  <= '{line_byte: bits, end_of_frame: 1'b0};
            bits      <= 8'h00;
            fill      <= 3'd0;
          end
          OP_CLOSE: begin
            out_valid <= 1'b1;
            out_data  <= '{line_byte: FLAG_BYTE, end_of_frame: 1'b1};
            ones      <= 3'd0;
          end
        endcase
      end
    end
  end

endmodule

/* sim/tb_top.sv */
// self-checking testbench for ax25_hdlc_frame_encoder: a scoreboard class predicts every line
// byte of the frames it is fed, random bursts and receiver stalls drive the handshakes
// depends on ax25_pkg and the encoder rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ax25_pkg::*;

  localparam logic [1:0] KIND_SUPER = 2'd1;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int ITEM_TARGET = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;

  typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_BURSTY} rx_pattern_t;
  typedef enum {PICK_ZERO, PICK_ONES, PICK_BITS, PICK_TEXT} call_pick_t;

  class frame_scoreboard;
    logic [CALL_W-1:0] dest_call = '0;
    logic [CALL_W-1:0] src_call = '0;
    logic [15:0] crc = CRC_INIT;
    logic [7:0] bits = '0;
    int fill = 0;
    int ones_run = 0;
    bit open = 0;
    int errors = 0;
    out_t line_bytes_due[$];

    function void set_callsign(logic idx, logic [CALL_W-1:0] value);
      if (idx == CFG_DEST) dest_call = value;
      else src_call = value;
    endfunction

    function void emit(logic [7:0] b, logic eof);
      out_t o;
      o.line_byte = b;
      o.end_of_frame = eof;
      line_bytes_due.push_back(o);
    endfunction

    function void put_bit(logic b);
      if (b) bits[7 - fill] = 1'b1;
      fill++;
      if (fill == 8) begin
        emit(bits, 1'b0);
        bits = '0;
        fill = 0;
      end
    endfunction

    // lsb first, zero inserted after five ones
    function void send_byte(logic [7:0] b);
      for (int i = 0; i < 8; i++) begin
        put_bit(b[i]);
        if (b[i]) begin
          ones_run++;
          if (ones_run == 5) begin
            put_bit(1'b0);
            ones_run = 0;
          end
        end else begin
          ones_run = 0;
        end
      end
    endfunction

    function void framed_byte(logic [7:0] b);
      crc ^= {b, 8'h00};
      for (int i = 0; i < 8; i++) crc = crc[15] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
      send_byte(b);
    endfunction

    function void clear_frame();
      crc = CRC_INIT;
      bits = '0;
      fill = 0;
      ones_run = 0;
    endfunction

    function void take_payload(in_t it);
      logic [7:0] ctrl;
      logic [15:0] fcs;
      if (!it.first_of_frame && !open) return;
      if (it.first_of_frame) begin
        clear_frame();
        open = 1;
        emit(FLAG_BYTE, 1'b0);
        for (int k = 5; k >= 0; k--) framed_byte({dest_call[8*k +: 7], 1'b0});
        framed_byte(SSID_BASE | (DEST_SSID_BITS + {6'd0, it.data_type, 1'b0})
                    | {it.command_flag, 7'd0});
        for (int k = 5; k >= 0; k--) framed_byte({src_call[8*k +: 7], 1'b0});
        framed_byte(SSID_BASE | SRC_SSID_BITS | {~it.command_flag, 7'd0});
        case (it.frame_kind)
          KIND_INFO: ctrl = {it.recv_seq, 1'b0, it.send_seq, 1'b0};
          KIND_UNNUM: ctrl = U_CTRL;
          default: ctrl = 8'h00;
        endcase
        framed_byte(ctrl);
        framed_byte(8'h00);
      end
      framed_byte(it.payload_byte);
      if (it.last_of_frame) begin
        fcs = ~crc;
        send_byte(fcs[15:8]);
        send_byte(fcs[7:0]);
        emit(bits, 1'b0);
        emit(FLAG_BYTE, 1'b1);
        clear_frame();
        open = 0;
      end
    endfunction

    function void check_line_byte(out_t got);
      out_t want;
      if (line_bytes_due.size() == 0) begin
        errors++;
        $display("%0t: line byte with nothing due, actual %h eof %b", $time,
                 got.line_byte, got.end_of_frame);
        return;
      end
      want = line_bytes_due.pop_front();
      if (got.line_byte !== want.line_byte) begin
        errors++;
        $display("%0t: line_byte expected %h actual %h", $time, want.line_byte, got.line_byte);
      end
      if (got.end_of_frame !== want.end_of_frame) begin
        errors++;
        $display("%0t: end_of_frame expected %b actual %b", $time, want.end_of_frame,
                 got.end_of_frame);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_DEST;
  logic [CALL_W-1:0] cfg_data = '0;

  frame_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;
  int items_sent = 0;
  bit frame_open = 0;
  bit hold_off = 0;

  ax25_hdlc_frame_encoder u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.take_payload(in_data);
      if (out_valid && out_ready) sb.check_line_byte(out_data);
      idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: long hold-off on request, otherwise segments of a random stall pattern
  initial begin
    rx_pattern_t pattern;
    int span;
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 0;
      end else begin
        pattern = rx_pattern_t'($urandom_range(0, 3));
        span = $urandom_range(20, 80);
        repeat (span) begin
          case (pattern)
            RX_OPEN: out_ready <= 1'b1;
            RX_HALF: out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 15) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic in_t rand_item();
    logic [31:0] raw;
    raw = $urandom;
    return raw[$bits(in_t)-1:0];
  endfunction

  function automatic logic [CALL_W-1:0] rand_callsign();
    logic [CALL_W-1:0] cs;
    logic [7:0] ch;
    call_pick_t pick;
    cs = '0;
    pick = call_pick_t'($urandom_range(0, 3));
    case (pick)
      PICK_ZERO: cs = '0;
      PICK_ONES: cs = '1;
      PICK_BITS: cs = {16'($urandom), $urandom};
      default: begin
        for (int k = 0; k < 6; k++) begin
          ch = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(48, 57))
                                           : 8'($urandom_range(65, 90));
          cs = {cs[CALL_W-9:0], ch};
        end
      end
    endcase
    return cs;
  endfunction

  task automatic send_item(input in_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic send_frame(input int len, input bit close);
    in_t it;
    for (int k = 0; k < len; k++) begin
      it = rand_item();
      it.first_of_frame = (k == 0);
      it.last_of_frame = close && (k == len - 1);
      send_item(it);
    end
    items_sent += len;
    frame_open = !close;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.line_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_callsign(input logic idx, input logic [CALL_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_callsign(idx, value);
    @(posedge clk);
  endtask

  initial begin
    in_t it;
    int len;
    bit close;
    int next_cfg;
    bit hold_done;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // byte outside a frame, then single-byte frames with the callsigns at reset
    send_item(in_t'{8'h55, 1'b0, 1'b0, KIND_INFO, 3'd0, 3'd0, 1'b0, 1'b0});
    send_item(in_t'{8'hFF, 1'b1, 1'b1, KIND_INFO, 3'd7, 3'd7, 1'b1, 1'b1});
    send_item(in_t'{8'h00, 1'b1, 1'b1, KIND_INFO, 3'd0, 3'd0, 1'b0, 1'b0});
    wait_drained();
    write_callsign(CFG_DEST, '1);
    write_callsign(CFG_SRC, '0);
    send_item(in_t'{8'h00, 1'b1, 1'b0, KIND_UNNUM, 3'd5, 3'd2, 1'b0, 1'b1});
    send_item(in_t'{8'hFF, 1'b0, 1'b1, KIND_SPARE, 3'd1, 3'd6, 1'b1, 1'b0});
    wait_drained();
    write_callsign(CFG_DEST, '0);
    write_callsign(CFG_SRC, '1);
    send_item(in_t'{8'hFF, 1'b1, 1'b0, KIND_SUPER, 3'd3, 3'd4, 1'b1, 1'b0});
    send_item(in_t'{8'hFF, 1'b0, 1'b0, KIND_INFO, 3'd0, 3'd0, 1'b0, 1'b0});
    send_item(in_t'{8'h7E, 1'b0, 1'b1, KIND_INFO, 3'd0, 3'd0, 1'b0, 1'b0});
    // spare kind, then a restart inside the open frame
    send_item(in_t'{8'hA5, 1'b1, 1'b0, KIND_SPARE, 3'd6, 3'd1, 1'b0, 1'b1});
    send_item(in_t'{8'h3C, 1'b0, 1'b0, KIND_INFO, 3'd0, 3'd0, 1'b0, 1'b0});
    send_item(in_t'{8'hC3, 1'b1, 1'b0, KIND_INFO, 3'd2, 3'd5, 1'b1, 1'b1});
    send_item(in_t'{8'h0F, 1'b0, 1'b1, KIND_INFO, 3'd0, 3'd0, 1'b0, 1'b0});
    // stray bytes after the frame closed, one claiming to be last
    send_item(in_t'{8'hF0, 1'b0, 1'b0, KIND_UNNUM, 3'd7, 3'd7, 1'b1, 1'b1});
    send_item(in_t'{8'h81, 1'b0, 1'b1, KIND_INFO, 3'd0, 3'd0, 1'b0, 1'b0});
    wait_drained();
    write_callsign(CFG_DEST, 48'h4E4F43414C4C);
    write_callsign(CFG_SRC, 48'h544553543031);
    send_item(in_t'{8'h7E, 1'b1, 1'b0, KIND_UNNUM, 3'd0, 3'd0, 1'b1, 1'b0});
    send_item(in_t'{8'h01, 1'b0, 1'b1, KIND_INFO, 3'd0, 3'd0, 1'b0, 1'b0});

    items_sent = 0;
    next_cfg = 70;
    hold_done = 0;
    while (items_sent < ITEM_TARGET) begin
      if (!frame_open && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          it = rand_item();
          it.first_of_frame = 1'b0;
          send_item(it);
        end
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
      close = ($urandom_range(0, 9) != 0);
      send_frame(len, close);
      if (!hold_done && items_sent >= 120) begin
        hold_off = 1;
        hold_done = 1;
      end
      if (close && items_sent >= next_cfg) begin
        wait_drained();
        write_callsign(CFG_DEST, rand_callsign());
        write_callsign(CFG_SRC, rand_callsign());
        next_cfg += 70;
      end
    end
    if (frame_open) send_frame(1, 1'b1);

    wait_drained();
    if (sb.errors == 0 && sb.line_bytes_due.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* ax25_hdlc_frame_encoder.f */
+incdir+hw/rtl
hw/rtl/ax25_pkg.sv
hw/rtl/ax25_crc.sv
hw/rtl/ax25_line.sv
hw/rtl/ax25_hdlc_frame_encoder.sv
sim/tb_top.sv
